// ----- src/bj3_pkg.sv -----
// ----------------------------------------------------------------------------
// bj3_pkg: shared types and constants of the 3x3 block Jacobi apply unit
// Widths of the fixed-point datapath, register indexes, cofactor tables.
// ----------------------------------------------------------------------------
package bj3_pkg;

  localparam int unsigned BLOCK_SIZE = 3;
  localparam int unsigned K_NUM      = BLOCK_SIZE * BLOCK_SIZE;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned IDX_W      = 24;

  // exact datapath widths
  localparam int unsigned PROD_W = 2 * DATA_W;           // 32x32 product
  localparam int unsigned COF_W  = PROD_W + 1;           // difference of products
  localparam int unsigned PART_W = COF_W;                // 33x32 partial product
  localparam int unsigned TERM_W = COF_W + DATA_W;       // cofactor times entry
  localparam int unsigned SUM_W  = TERM_W + 2;           // sum of three terms
  localparam int unsigned NUM_W  = SUM_W + FRAC_W;       // scaled numerator
  localparam int unsigned DEN_W  = SUM_W;
  localparam int unsigned Q_W    = DATA_W;
  localparam int unsigned DIV_W  = DEN_W + Q_W + 1;      // divisor shifted by Q_W

  localparam int unsigned NUM_TERMS  = 12;
  localparam int unsigned DIV_STAGES = Q_W + 2;
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned PIPE_DEPTH = FRONT_STAGES + DIV_STAGES;

  localparam logic [Q_W-1:0] Y_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Y_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [0:0] {
    REG_MODE       = 1'b0,
    REG_NODE_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_DIAG  = 1'b0,
    MODE_BLOCK = 1'b1
  } mode_e;

  // cofactor c[r][c] = k[a]*k[b] - k[c]*k[d], flat index r*3+c
  localparam int unsigned COF_IDX [K_NUM][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  // terms: det first, then one group of three per numerator
  localparam int unsigned TERM_COF [NUM_TERMS] = '{0, 1, 2, 0, 3, 6, 1, 4, 7, 2, 5, 8};
  // operand: 0..2 = k00,k01,k02; 3..5 = x0,x1,x2
  localparam int unsigned TERM_OPD [NUM_TERMS] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};

endpackage

// ----- src/bj3_if.sv -----
// ----------------------------------------------------------------------------
// bj3 channel interfaces
// Node input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bj3_in_if;
  logic valid;
  logic ready;
  bj3_pkg::data_t k00, k01, k02, k10, k11, k12, k20, k21, k22;
  bj3_pkg::data_t x0, x1, x2;

  modport source (output valid, k00, k01, k02, k10, k11, k12, k20, k21, k22,
                  x0, x1, x2, input ready);
  modport sink (input valid, k00, k01, k02, k10, k11, k12, k20, k21, k22,
                x0, x1, x2, output ready);
endinterface

interface bj3_out_if;
  logic valid;
  logic ready;
  bj3_pkg::data_t y0, y1, y2;
  logic singular;
  logic last_node;

  modport source (output valid, y0, y1, y2, singular, last_node, input ready);
  modport sink (input valid, y0, y1, y2, singular, last_node, output ready);
endinterface

interface bj3_cfg_if;
  logic valid;
  logic ready;
  bj3_pkg::reg_idx_e index;
  logic [bj3_pkg::CNT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/block_jacobi_3x3_apply.sv -----
// ----------------------------------------------------------------------------
// block_jacobi_3x3_apply: per-node 3x3 block Jacobi preconditioner apply
// Streams one node per cycle unless stalled: y = K^-1 x (block mode) or
// y_i = x_i / K_ii (diagonal mode); signed Q16.16, truncated, saturated.
//
// Channels: in_i carries one node (block K and vector x) per transaction,
// out_o one result (y0..y2, singular, last_node). cfg_i writes mode (index
// 0) and node_count (index 1); it is always ready and must only be used
// while no node is in flight.
// Throughput: one node per unstalled cycle, by the fully pipelined datapath:
// 7 stages of products, cofactors and sums, then three 34-stage dividers.
// Stall: the whole pipeline holds while a result waits on out_o; a skid
// register still takes one more input transaction during the stall.
// Reset: pipeline empties, mode = diagonal, node_count = 1, pass index 0.
// A zero pivot or zero determinant gives zero outputs with singular set.
// ----------------------------------------------------------------------------
module block_jacobi_3x3_apply (
  input  logic       clk_i,
  input  logic       rst_ni,
  bj3_cfg_if.sink    cfg_i,
  bj3_in_if.sink     in_i,
  bj3_out_if.source  out_o
);

  localparam int unsigned KN = bj3_pkg::K_NUM;
  localparam int unsigned BS = bj3_pkg::BLOCK_SIZE;
  localparam int unsigned NT = bj3_pkg::NUM_TERMS;
  localparam int unsigned PD = bj3_pkg::PIPE_DEPTH;
  localparam int unsigned DS = bj3_pkg::DIV_STAGES;

  // configuration and pass counter
  bj3_pkg::mode_e             mode_q;
  logic [bj3_pkg::CNT_W-1:0]  node_count_q;
  logic [bj3_pkg::IDX_W-1:0]  node_idx_q;
  logic [bj3_pkg::IDX_W-1:0]  node_idx_d;
  logic                       last_in;

  logic adv;
  logic in_acc;

  // skid
  logic           skid_full_q;
  bj3_pkg::data_t skid_k_q [KN];
  bj3_pkg::data_t skid_x_q [BS];
  logic           skid_last_q;
  bj3_pkg::data_t in_k [KN];
  bj3_pkg::data_t in_x [BS];

  // pipeline
  logic [PD-1:0]  v_q;
  logic [PD-1:0]  last_q;
  logic [DS:0]    sing_q;
  bj3_pkg::data_t k_q [6][KN];
  bj3_pkg::data_t x_q [6][BS];

  logic signed [bj3_pkg::PROD_W-1:0] pa_q [KN];
  logic signed [bj3_pkg::PROD_W-1:0] pb_q [KN];
  logic signed [bj3_pkg::COF_W-1:0]  cof_q [KN];
  logic signed [bj3_pkg::PART_W-1:0] pl_q [NT];
  logic signed [bj3_pkg::PART_W-1:0] ph_q [NT];
  logic signed [bj3_pkg::TERM_W-1:0] term_q [NT];
  logic signed [bj3_pkg::SUM_W-1:0]  sum_q [BS+1];

  logic signed [bj3_pkg::NUM_W-1:0]  num_d [BS];
  logic signed [bj3_pkg::DEN_W-1:0]  den_d [BS];
  logic                              sing_d;
  logic signed [bj3_pkg::NUM_W-1:0]  num_q [BS];
  logic signed [bj3_pkg::DEN_W-1:0]  den_q [BS];
  logic [bj3_pkg::Q_W-1:0]           y_div [BS];

  // output register
  logic                    out_valid_q;
  logic [bj3_pkg::Q_W-1:0] y_q [BS];
  logic                    sing_out_q;
  logic                    last_out_q;

  assign adv    = !out_valid_q || out_o.ready;
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready  = !skid_full_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= bj3_pkg::MODE_DIAG;
      node_count_q <= bj3_pkg::CNT_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bj3_pkg::REG_MODE:       mode_q <= bj3_pkg::mode_e'(cfg_i.data[0]);
        bj3_pkg::REG_NODE_COUNT: node_count_q <= cfg_i.data;
      endcase
    end
  end

  always_comb begin
    last_in    = ({1'b0, node_idx_q} + bj3_pkg::CNT_W'(1)) >= node_count_q;
    node_idx_d = last_in ? '0 : node_idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_idx_q <= '0;
    end else if (in_acc) begin
      node_idx_q <= node_idx_d;
    end
  end

  always_comb begin
    in_k[0] = in_i.k00; in_k[1] = in_i.k01; in_k[2] = in_i.k02;
    in_k[3] = in_i.k10; in_k[4] = in_i.k11; in_k[5] = in_i.k12;
    in_k[6] = in_i.k20; in_k[7] = in_i.k21; in_k[8] = in_i.k22;
    in_x[0] = in_i.x0;  in_x[1] = in_i.x1;  in_x[2] = in_i.x2;
  end

  // skid takes one transaction while the pipeline is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (adv) begin
      skid_full_q <= 1'b0;
    end else if (in_acc) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !adv) begin
      skid_k_q    <= in_k;
      skid_x_q    <= in_x;
      skid_last_q <= last_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[PD-2:0], skid_full_q || in_acc};
      out_valid_q <= v_q[PD-1];
    end
  end

  // front end: products, cofactors, partial products, terms, sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_q[0]    <= skid_full_q ? skid_k_q : in_k;
      x_q[0]    <= skid_full_q ? skid_x_q : in_x;
      last_q    <= {last_q[PD-2:0], skid_full_q ? skid_last_q : last_in};
      for (int s = 1; s < 6; s++) begin
        k_q[s] <= k_q[s-1];
        x_q[s] <= x_q[s-1];
      end
      for (int c = 0; c < KN; c++) begin
        pa_q[c]  <= bj3_pkg::PROD_W'(k_q[0][bj3_pkg::COF_IDX[c][0]])
                  * bj3_pkg::PROD_W'(k_q[0][bj3_pkg::COF_IDX[c][1]]);
        pb_q[c]  <= bj3_pkg::PROD_W'(k_q[0][bj3_pkg::COF_IDX[c][2]])
                  * bj3_pkg::PROD_W'(k_q[0][bj3_pkg::COF_IDX[c][3]]);
        cof_q[c] <= bj3_pkg::COF_W'(pa_q[c]) - bj3_pkg::COF_W'(pb_q[c]);
      end
      for (int s = 0; s <= BS; s++) begin
        sum_q[s] <= bj3_pkg::SUM_W'(term_q[3*s]) + bj3_pkg::SUM_W'(term_q[3*s+1])
                  + bj3_pkg::SUM_W'(term_q[3*s+2]);
      end
    end
  end

  for (genvar t = 0; t < NT; t++) begin : g_term
    localparam int unsigned CI = bj3_pkg::TERM_COF[t];
    localparam int unsigned OI = bj3_pkg::TERM_OPD[t];
    bj3_pkg::data_t opd;

    if (OI < BS) begin : g_k
      assign opd = k_q[2][OI];
    end else begin : g_x
      assign opd = x_q[2][OI-BS];
    end

    // cofactor split at bit 32 keeps each multiply near 32x32
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pl_q[t]   <= bj3_pkg::PART_W'($signed({1'b0, cof_q[CI][bj3_pkg::DATA_W-1:0]}))
                   * bj3_pkg::PART_W'(opd);
        ph_q[t]   <= bj3_pkg::PART_W'($signed(cof_q[CI][bj3_pkg::COF_W-1:bj3_pkg::DATA_W]))
                   * bj3_pkg::PART_W'(opd);
        term_q[t] <= (bj3_pkg::TERM_W'(ph_q[t]) <<< bj3_pkg::DATA_W)
                   + bj3_pkg::TERM_W'(pl_q[t]);
      end
    end
  end

  // operand select for the dividers
  always_comb begin
    if (mode_q == bj3_pkg::MODE_BLOCK) begin
      sing_d = (sum_q[0] == '0);
      for (int i = 0; i < BS; i++) begin
        num_d[i] = bj3_pkg::NUM_W'(sum_q[i+1]) <<< bj3_pkg::FRAC_W;
        den_d[i] = sum_q[0];
      end
    end else begin
      sing_d = 1'b0;
      for (int i = 0; i < BS; i++) begin
        if (k_q[5][i*(BS+1)] == '0) begin
          sing_d = 1'b1;
        end
        num_d[i] = bj3_pkg::NUM_W'(x_q[5][i]) <<< bj3_pkg::FRAC_W;
        den_d[i] = bj3_pkg::DEN_W'(k_q[5][i*(BS+1)]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q  <= num_d;
      den_q  <= den_d;
      sing_q <= {sing_q[DS-1:0], sing_d};
    end
  end

  for (genvar i = 0; i < BS; i++) begin : g_lane
    bj3_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[i]),
      .den_i (den_q[i]),
      .y_o   (y_div[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < BS; i++) begin
        y_q[i] <= sing_q[DS] ? '0 : y_div[i];
      end
      sing_out_q <= sing_q[DS];
      last_out_q <= last_q[PD-1];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.y0        = y_q[0];
  assign out_o.y1        = y_q[1];
  assign out_o.y2        = y_q[2];
  assign out_o.singular  = sing_out_q;
  assign out_o.last_node = last_out_q;

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sing_out_q |-> y_q[0] == '0 && y_q[1] == '0 && y_q[2] == '0)
    else $error("singular result with nonzero data");

  a_pass_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_in |=> node_idx_q == '0)
    else $error("pass index did not return to zero");

  a_skid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && !adv |=> skid_full_q)
    else $error("skid transaction lost during stall");

  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && adv |=> !skid_full_q && v_q[0])
    else $error("skid transaction not moved into pipeline");

  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline moved while stalled");

endmodule

// ----- src/bj3_div.sv -----
// ----------------------------------------------------------------------------
// bj3_div: pipelined signed divider with 32-bit saturated quotient
// Truncates toward zero. Magnitude stage, one overflow check stage, then one
// quotient bit per stage; accepts a new operand pair every enabled cycle.
// ----------------------------------------------------------------------------
module bj3_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [bj3_pkg::NUM_W-1:0]  num_i,
  input  logic signed [bj3_pkg::DEN_W-1:0]  den_i,
  output logic        [bj3_pkg::Q_W-1:0]    y_o
);

  localparam int unsigned NW = bj3_pkg::NUM_W;
  localparam int unsigned DW = bj3_pkg::DEN_W;
  localparam int unsigned RW = bj3_pkg::DIV_W;
  localparam int unsigned QW = bj3_pkg::Q_W;

  logic [NW-1:0] n_mag_q;
  logic [DW-1:0] d_mag_q;
  logic          neg0_q;

  logic [RW-1:0] rem_q [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          neg_q [QW+1];
  logic          sat_q [QW+1];

  // magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_mag_q <= num_i[NW-1] ? NW'(~num_i + 1'b1) : NW'(num_i);
      d_mag_q <= den_i[DW-1] ? DW'(~den_i + 1'b1) : DW'(den_i);
      neg0_q  <= num_i[NW-1] ^ den_i[DW-1];
    end
  end

  // quotient of 2^32 or more saturates regardless of sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(n_mag_q);
      d_q[0]   <= d_mag_q;
      q_q[0]   <= '0;
      neg_q[0] <= neg0_q;
      sat_q[0] <= RW'(n_mag_q) >= (RW'(d_mag_q) << QW);
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int unsigned B = QW - 1 - i;
    logic [RW:0]   diff;
    logic          fits;

    always_comb begin
      diff = {1'b0, rem_q[i]} - {1'b0, (RW'(d_q[i]) << B)};
      fits = !diff[RW];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= fits ? diff[RW-1:0] : rem_q[i];
        q_q[i+1]   <= q_q[i] | (QW'(fits) << B);
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
        sat_q[i+1] <= sat_q[i];
      end
    end
  end

  always_comb begin
    if (sat_q[QW]) begin
      y_o = neg_q[QW] ? bj3_pkg::Y_MIN : bj3_pkg::Y_MAX;
    end else if (neg_q[QW]) begin
      y_o = (q_q[QW] > bj3_pkg::Y_MIN) ? bj3_pkg::Y_MIN : QW'(~q_q[QW] + 1'b1);
    end else begin
      y_o = q_q[QW][QW-1] ? bj3_pkg::Y_MAX : q_q[QW];
    end
  end

endmodule

// ----- verif/bj3_checker.sv -----
// ----------------------------------------------------------------------------
// bj3_checker: result predictor and scoreboard for block_jacobi_3x3_apply
// Tracks register writes, predicts one result per accepted node transaction
// and compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module bj3_checker
  import bj3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bj3_cfg_if   cfg_i,
  bj3_in_if    in_i,
  bj3_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    data_t y0, y1, y2;
    logic  singular;
    logic  last_node;
  } precond_res_t;

  typedef logic signed [127:0] wide_t;

  mode_e              cur_mode;
  logic [CNT_W-1:0]   cur_count;
  logic [IDX_W-1:0]   cur_index;
  precond_res_t       exp_q[$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = exp_q.size();

  function automatic data_t sat32(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return Y_MAX;
    if (v < -wide_t'(64'sh80000000)) return Y_MIN;
    return data_t'(v[31:0]);
  endfunction

  function automatic wide_t cf(data_t a, data_t b, data_t c, data_t d);
    return wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
  endfunction

  // exact solve of one node, each quotient truncated toward zero once
  function automatic precond_res_t solve_node(mode_e m, data_t k[9], data_t x[3]);
    precond_res_t r;
    wide_t c[9];
    wide_t det, n0, n1, n2;
    r = '0;
    if (m == MODE_DIAG) begin
      if (k[0] == 0 || k[4] == 0 || k[8] == 0) begin
        r.singular = 1'b1;
      end else begin
        r.y0 = sat32((wide_t'(x[0]) * 65536) / wide_t'(k[0]));
        r.y1 = sat32((wide_t'(x[1]) * 65536) / wide_t'(k[4]));
        r.y2 = sat32((wide_t'(x[2]) * 65536) / wide_t'(k[8]));
      end
    end else begin
      c[0] = cf(k[4], k[8], k[5], k[7]);
      c[1] = cf(k[5], k[6], k[3], k[8]);
      c[2] = cf(k[3], k[7], k[4], k[6]);
      c[3] = cf(k[2], k[7], k[1], k[8]);
      c[4] = cf(k[0], k[8], k[2], k[6]);
      c[5] = cf(k[1], k[6], k[0], k[7]);
      c[6] = cf(k[1], k[5], k[2], k[4]);
      c[7] = cf(k[2], k[3], k[0], k[5]);
      c[8] = cf(k[0], k[4], k[1], k[3]);
      det = c[0] * k[0] + c[1] * k[1] + c[2] * k[2];
      if (det == 0) begin
        r.singular = 1'b1;
      end else begin
        n0 = c[0] * x[0] + c[3] * x[1] + c[6] * x[2];
        n1 = c[1] * x[0] + c[4] * x[1] + c[7] * x[2];
        n2 = c[2] * x[0] + c[5] * x[1] + c[8] * x[2];
        r.y0 = sat32((n0 * 65536) / det);
        r.y1 = sat32((n1 * 65536) / det);
        r.y2 = sat32((n2 * 65536) / det);
      end
    end
    return r;
  endfunction

  task automatic flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, exp_v, act_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    data_t        k[9];
    data_t        x[3];
    precond_res_t e, a;
    logic         last;
    if (!rst_ni) begin
      cur_mode  <= MODE_DIAG;
      cur_count <= CNT_W'(1);
      cur_index <= '0;
      exp_q.delete();
      fails     <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_MODE) cur_mode <= mode_e'(cfg_i.data[0]);
        else                         cur_count <= cfg_i.data;
      end
      if (in_i.valid && in_i.ready) begin
        k = '{in_i.k00, in_i.k01, in_i.k02, in_i.k10, in_i.k11, in_i.k12,
              in_i.k20, in_i.k21, in_i.k22};
        x = '{in_i.x0, in_i.x1, in_i.x2};
        e = solve_node(cur_mode, k, x);
        last = ({1'b0, cur_index} + 26'd1) >= {1'b0, cur_count};
        e.last_node = last;
        cur_index <= last ? '0 : cur_index + 1'b1;
        exp_q.push_back(e);
      end
      if (out_i.valid && out_i.ready) begin
        a = '{out_i.y0, out_i.y1, out_i.y2, out_i.singular, out_i.last_node};
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, a);
          fails++;
        end else begin
          e = exp_q.pop_front();
          if (a.y0 !== e.y0) flag("y0", e.y0, a.y0);
          if (a.y1 !== e.y1) flag("y1", e.y1, a.y1);
          if (a.y2 !== e.y2) flag("y2", e.y2, a.y2);
          if (a.singular !== e.singular) flag("singular", e.singular, a.singular);
          if (a.last_node !== e.last_node) flag("last_node", e.last_node, a.last_node);
        end
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for block_jacobi_3x3_apply
// Directed corner nodes, then phases of random nodes under several register
// settings, with bursty input traffic and patterned output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import bj3_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  bj3_cfg_if cfg_if ();
  bj3_in_if  in_if ();
  bj3_out_if out_if ();

  block_jacobi_3x3_apply u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bj3_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("block_jacobi_3x3_apply verification failed");
    $finish;
  end

  // output back-pressure: pattern re-chosen at random
  always @(negedge clk_i) begin
    static int cyc = 0;
    static int pat = 0;
    if (cyc % 64 == 0) pat = $urandom_range(0, 4);
    case (pat)
      0, 1:    out_if.ready = 1'b1;
      2:       out_if.ready = $urandom_range(0, 1);
      3:       out_if.ready = (cyc % 4 == 0);
      default: out_if.ready = ((cyc / 8) % 2 == 0);
    endcase
    cyc++;
  end

  function automatic data_t rand_entry();
    case ($urandom_range(0, 11))
      0:       return 32'sh0;
      1:       return 32'sh80000000;
      2:       return 32'sh7fffffff;
      3, 4:    return data_t'($urandom);
      5:       return data_t'($urandom_range(0, 255)) - 128;
      default: return data_t'($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic drive_node(data_t k[9], data_t x[3]);
    in_if.valid = 1'b1;
    {in_if.k00, in_if.k01, in_if.k02} = {k[0], k[1], k[2]};
    {in_if.k10, in_if.k11, in_if.k12} = {k[3], k[4], k[5]};
    {in_if.k20, in_if.k21, in_if.k22} = {k[6], k[7], k[8]};
    {in_if.x0, in_if.x1, in_if.x2} = {x[0], x[1], x[2]};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  // well-formed most of the time: dominant diagonal, sometimes a repeated row
  task automatic rand_node();
    data_t k[9];
    data_t x[3];
    int    kind;
    kind = $urandom_range(0, 9);
    foreach (k[i]) k[i] = rand_entry();
    foreach (x[i]) x[i] = rand_entry();
    if (kind < 6) begin
      foreach (k[i]) k[i] = data_t'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      k[0] = k[0] + ((kind[0]) ? 32'sh00100000 : -32'sh00100000);
      k[4] = k[4] + 32'sh00180000;
      k[8] = k[8] - 32'sh00140000;
    end else if (kind == 6) begin
      k[6] = k[0]; k[7] = k[1]; k[8] = k[2];
    end
    drive_node(k, x);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CNT_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 10) @(negedge clk_i);
  endtask

  task automatic directed_set();
    data_t k[9];
    data_t x[3];
    // identity, extreme vectors
    k = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    x = '{32'sh7fffffff, 32'sh80000000, 32'sh0};
    drive_node(k, x);
    // tiny pivots saturate both ways
    k = '{1, 0, 0, 0, -1, 0, 0, 0, 32'sh80000000};
    x = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
    drive_node(k, x);
    k = '{32'sh7fffffff, -1, -1, -1, 32'sh80000000, -1, -1, -1, -1};
    x = '{-1, 1, 32'sh80000000};
    drive_node(k, x);
    // zero pivot / zero determinant (all zero, then repeated row)
    k = '{32'sh10000, 5, 7, 3, 0, 2, 1, 1, 32'sh20000};
    x = '{32'sh30000, -32'sh30000, 32'sh1};
    drive_node(k, x);
    k = '{default: 0};
    drive_node(k, x);
    k = '{32'sh20000, 32'sh10000, 3, 7, 32'sh40000, 9, 32'sh20000, 32'sh10000, 3};
    drive_node(k, x);
    // rounding toward zero with negative signs
    k = '{-32'sh30000, 1, 2, 3, 32'sh30000, 4, 5, 6, -7};
    x = '{32'sh10000, -32'sh10000, 32'sh5};
    drive_node(k, x);
    k = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    x = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    drive_node(k, x);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    {in_if.k00, in_if.k01, in_if.k02, in_if.k10, in_if.k11, in_if.k12} = '0;
    {in_if.k20, in_if.k21, in_if.k22, in_if.x0, in_if.x1, in_if.x2} = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MODE;
    cfg_if.data  = '0;
    burst_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings first: diagonal mode, one node per pass
    directed_set();
    drain();
    write_reg(REG_MODE, CNT_W'(MODE_BLOCK));
    write_reg(REG_NODE_COUNT, CNT_W'(3));
    directed_set();
    drain();
    // pass shortened while mid pass
    write_reg(REG_NODE_COUNT, CNT_W'(10));
    repeat (7) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, CNT_W'(4));
    repeat (4) rand_node();
    drain();

    write_reg(REG_NODE_COUNT, CNT_W'(0));
    write_reg(REG_MODE, 25'h1fffffe);
    repeat (100) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, 25'h1ffffff);
    write_reg(REG_MODE, 25'h1);
    repeat (110) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, 25'h1000000);
    write_reg(REG_MODE, CNT_W'(MODE_DIAG));
    repeat (100) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, CNT_W'(1));
    write_reg(REG_MODE, CNT_W'(MODE_BLOCK));
    repeat (110) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, CNT_W'(7));
    write_reg(REG_MODE, CNT_W'(MODE_DIAG));
    repeat (100) rand_node();
    drain();
    write_reg(REG_NODE_COUNT, CNT_W'(13));
    write_reg(REG_MODE, CNT_W'(MODE_BLOCK));
    repeat (110) rand_node();
    drain();

    if (fail_count == 0) begin
      $display("block_jacobi_3x3_apply verification clean");
    end else begin
      $display("block_jacobi_3x3_apply verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bj3_pkg.sv
src/bj3_if.sv
src/bj3_div.sv
src/block_jacobi_3x3_apply.sv
verif/bj3_checker.sv
verif/testbench.sv
